>>> rtl/spi_duty_command_slave_failsafe_unit_macros.svh
// Assertion helpers shared by the RTL files of the duty command block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SPI_DUTY_COMMAND_SLAVE_FAILSAFE_UNIT_MACROS_SVH
`define SPI_DUTY_COMMAND_SLAVE_FAILSAFE_UNIT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define SDCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define SDCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/sdcs_pkg.sv
package sdcs_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_CODE    = 3'd0,
    CFG_DUTY_MAX      = 3'd1,
    CFG_FAILSAFE_DUTY = 3'd2,
    CFG_TIMEOUT_TICKS = 3'd3,
    CFG_BLINK_DIVIDE  = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] START_CODE_RST    = 16'h00DA;
  localparam logic [14:0] DUTY_MAX_RST      = 15'd3000;
  localparam logic [14:0] FAILSAFE_DUTY_RST = 15'd1500;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd200;
  localparam logic [15:0] BLINK_DIVIDE_RST  = 16'd500;
  localparam logic [14:0] DUTY_RST          = 15'd1500;

  // Request types carried in req_type.
  localparam logic REQ_SPI_WORD = 1'b0;
  localparam logic REQ_ADC_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] start_code;
    logic [14:0] duty_max;
    logic [14:0] failsafe_duty;
    logic [15:0] timeout_ticks;
    logic [15:0] blink_divide;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] spi_word;
    logic [11:0]        adc_first;
    logic [11:0]        adc_second;
  } in_item_t;

  typedef struct packed {
    logic        tx_load;
    logic [11:0] tx_word;
    logic [14:0] duty_a;
    logic [14:0] duty_b;
    logic        duty_written;
    logic        pin_toggle;
    logic        in_frame;
  } out_item_t;

endpackage

>>> rtl/sdcs_core.sv
`include "spi_duty_command_slave_failsafe_unit_macros.svh"

module sdcs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  sdcs_pkg::cfg_t       cfg_i,
  input  sdcs_pkg::in_item_t   item_i,
  output sdcs_pkg::out_item_t  result_o
);
  import sdcs_pkg::*;

  typedef enum logic [1:0] {
    POS_IDLE   = 2'd0,
    POS_FIRST  = 2'd1,
    POS_SECOND = 2'd2
  } pos_e;

  localparam logic [16:0] SilenceMax = 17'h1FFFF;

  logic        frame_q, frame_d;
  pos_e        pos_q, pos_d;
  logic [11:0] latest_first_q, latest_first_d;
  logic [11:0] latest_second_q, latest_second_d;
  logic [11:0] reply_second_q, reply_second_d;
  logic [15:0] first_word_q, first_word_d;
  logic [14:0] duty_a_q, duty_a_d;
  logic [14:0] duty_b_q, duty_b_d;
  logic [15:0] blink_q, blink_d;
  logic [16:0] silence_q, silence_d;
  out_item_t   res;

  // Negative words clamp to zero, large positive words to the configured maximum.
  function automatic logic [14:0] clamp_duty(logic [15:0] raw, logic [14:0] max_val);
    logic [14:0] val;
    val = raw[14:0];
    if (raw[15]) begin
      return '0;
    end else if (val > max_val) begin
      return max_val;
    end
    return val;
  endfunction

  always_comb begin
    logic [15:0] word;
    logic [15:0] div;
    logic [16:0] blink_inc;
    logic [16:0] silence_inc;

    word        = item_i.spi_word;
    div         = (cfg_i.blink_divide == '0) ? 16'd1 : cfg_i.blink_divide;
    blink_inc   = {1'b0, blink_q} + 17'd1;
    silence_inc = (silence_q == SilenceMax) ? silence_q : silence_q + 17'd1;

    frame_d         = frame_q;
    pos_d           = pos_q;
    latest_first_d  = latest_first_q;
    latest_second_d = latest_second_q;
    reply_second_d  = reply_second_q;
    first_word_d    = first_word_q;
    duty_a_d        = duty_a_q;
    duty_b_d        = duty_b_q;
    blink_d         = blink_q;
    silence_d       = silence_q;
    res             = '0;

    if (item_i.req_type == REQ_SPI_WORD) begin
      if (!frame_q) begin
        if (word == cfg_i.start_code) begin
          frame_d        = 1'b1;
          pos_d          = POS_FIRST;
          res.tx_load    = 1'b1;
          res.tx_word    = latest_first_q;
          reply_second_d = latest_second_q;
        end else begin
          pos_d          = POS_IDLE;
          reply_second_d = '0;
        end
      end else if (pos_q == POS_FIRST) begin
        res.tx_load  = 1'b1;
        res.tx_word  = reply_second_q;
        first_word_d = word;
        pos_d        = POS_SECOND;
      end else begin
        // Any other position inside a frame is taken as the final duty word.
        res.tx_load      = 1'b1;
        res.tx_word      = '0;
        frame_d          = 1'b0;
        pos_d            = POS_IDLE;
        duty_a_d         = clamp_duty(first_word_q, cfg_i.duty_max);
        duty_b_d         = clamp_duty(word, cfg_i.duty_max);
        silence_d        = '0;
        res.duty_written = 1'b1;
      end
    end else begin
      latest_first_d  = item_i.adc_first;
      latest_second_d = item_i.adc_second;
      if (blink_inc >= {1'b0, div}) begin
        blink_d        = '0;
        res.pin_toggle = 1'b1;
      end else begin
        blink_d = blink_inc[15:0];
      end
      silence_d = silence_inc;
      if (silence_inc > {1'b0, cfg_i.timeout_ticks}) begin
        duty_a_d         = cfg_i.failsafe_duty;
        duty_b_d         = cfg_i.failsafe_duty;
        res.duty_written = 1'b1;
      end
    end

    res.duty_a   = duty_a_d;
    res.duty_b   = duty_b_d;
    res.in_frame = frame_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q         <= 1'b0;
      pos_q           <= POS_IDLE;
      latest_first_q  <= '0;
      latest_second_q <= '0;
      reply_second_q  <= '0;
      first_word_q    <= '0;
      duty_a_q        <= DUTY_RST;
      duty_b_q        <= DUTY_RST;
      blink_q         <= '0;
      silence_q       <= '0;
    end else if (accept_i) begin
      frame_q         <= frame_d;
      pos_q           <= pos_d;
      latest_first_q  <= latest_first_d;
      latest_second_q <= latest_second_d;
      reply_second_q  <= reply_second_d;
      first_word_q    <= first_word_d;
      duty_a_q        <= duty_a_d;
      duty_b_q        <= duty_b_d;
      blink_q         <= blink_d;
      silence_q       <= silence_d;
    end
  end

  `SDCS_ASSERT(a_frame_matches_pos, frame_q == (pos_q != POS_IDLE), "frame flag and word position disagree")
  `SDCS_ASSERT_NEXT(a_frame_end_clears_silence, accept_i && (item_i.req_type == REQ_SPI_WORD) && frame_q && (pos_q != POS_FIRST), silence_q == '0, "frame end did not clear the silence counter")
  `SDCS_ASSERT_NEXT(a_toggle_wraps_blink, accept_i && result_o.pin_toggle, blink_q == '0, "pin toggle without blink counter wrap")

endmodule

>>> rtl/spi_duty_command_slave_failsafe_unit.sv
// A result is registered into the output register, or into the skid buffer while the output stalls.
// Throughput: one transaction per cycle while in_stall_o is low, set by the single state update in the command core.
// A two-entry output buffer keeps input acceptance going while the output stalls, until its second entry is full.
// Reset: asynchronous, active low; configuration returns to its defaults, both duties to 1500,
// all counters and frame state to zero, and the output buffer empties.
`include "spi_duty_command_slave_failsafe_unit_macros.svh"

module spi_duty_command_slave_failsafe_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  sdcs_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output sdcs_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_we_i,
  input  logic [sdcs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [sdcs_pkg::CfgDataW-1:0]        cfg_data_i
);
  import sdcs_pkg::*;

  cfg_t      cfg_q;
  out_item_t result;
  out_item_t out_q;
  out_item_t skid_q;
  logic      out_valid_q;
  logic      skid_valid_q;
  logic      in_accept;
  logic      out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code    <= START_CODE_RST;
      cfg_q.duty_max      <= DUTY_MAX_RST;
      cfg_q.failsafe_duty <= FAILSAFE_DUTY_RST;
      cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg_q.blink_divide  <= BLINK_DIVIDE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_CODE:    cfg_q.start_code    <= cfg_data_i;
        CFG_DUTY_MAX:      cfg_q.duty_max      <= cfg_data_i[14:0];
        CFG_FAILSAFE_DUTY: cfg_q.failsafe_duty <= cfg_data_i[14:0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data_i;
        CFG_BLINK_DIVIDE:  cfg_q.blink_divide  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_free  = !out_valid_q || !out_stall_i;

  sdcs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .cfg_i    (cfg_q),
    .item_i   (in_item_i),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= result;
      end
    end else if (in_accept) begin
      skid_q <= result;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SDCS_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "buffered result without an output result")
  `SDCS_ASSERT_NEXT(a_stall_fills_skid, out_valid_q && out_stall_i && in_accept, skid_valid_q, "stalled transaction was not buffered")
  `SDCS_ASSERT_NEXT(a_skid_drains, skid_valid_q && !out_stall_i, out_valid_q && !skid_valid_q, "buffered result did not move to the output")

endmodule
